### rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache: table size, status codes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;
   localparam int TS_W  = 32;
   localparam int ST_W  = 2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_INVALID   = 2'd2;

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_FILL  = 2'd1,
      OP_TOUCH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      SEL_HOLD  = 3'd0,
      SEL_HIT   = 3'd1,
      SEL_FREE  = 3'd2,
      SEL_FIRST = 3'd3,
      SEL_SCAN  = 3'd4
   } slot_sel_type;

   typedef struct packed {
      logic             load;
      slot_sel_type     slot_sel;
      logic             commit;
      op_type           op;
      logic [ST_W-1:0]  status;
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic ip_zero;
      logic hit;
      logic has_free;
      logic last_scan;
      logic rsp_free;
   } stat_type;

endpackage

### rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer of the ARP cache: takes a request, decides hit, fill or eviction
// from the match results, walks the LRU scan and commits the table update
// together with the response.
// ----------------------------------------------------------------------------
module arpc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  arpc_pkg::stat_type stat,
   output arpc_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_SCAN  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   arpc_pkg::op_type           op_ff, op_in;
   logic [arpc_pkg::ST_W-1:0]  st_ff, st_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      st_in        = st_ff;
      cmd.load     = 1'b0;
      cmd.slot_sel = arpc_pkg::SEL_HOLD;
      cmd.commit   = 1'b0;
      cmd.op       = op_ff;
      cmd.status   = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            st_in    = arpc_pkg::ST_OK;
            state_in = S_WRITE;
            if (!stat.is_lookup && stat.ip_zero) begin
               st_in = arpc_pkg::ST_INVALID;
               op_in = arpc_pkg::OP_NONE;
            end else if (stat.hit) begin
               cmd.slot_sel = arpc_pkg::SEL_HIT;
               op_in = stat.is_lookup ? arpc_pkg::OP_TOUCH : arpc_pkg::OP_FILL;
            end else if (stat.is_lookup) begin
               st_in = arpc_pkg::ST_NOT_FOUND;
               op_in = arpc_pkg::OP_NONE;
            end else if (stat.has_free) begin
               cmd.slot_sel = arpc_pkg::SEL_FREE;
               op_in = arpc_pkg::OP_FILL;
            end else begin
               // table full: oldest entry goes
               cmd.slot_sel = arpc_pkg::SEL_FIRST;
               op_in = arpc_pkg::OP_FILL;
               if (arpc_pkg::ENTRIES > 1) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.slot_sel = arpc_pkg::SEL_SCAN;
            if (stat.last_scan) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= arpc_pkg::OP_NONE;
         st_ff    <= arpc_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         st_ff    <= st_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### rtl/arpc_dp.sv
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath of the ARP cache: request registers, the entry table, parallel
// key match, the serial LRU compare and the response register.
// ----------------------------------------------------------------------------
module arpc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  arpc_pkg::cmd_type           cmd,
   output arpc_pkg::stat_type          stat,
   input  logic                        req_action,
   input  logic [arpc_pkg::IP_W-1:0]   req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]  req_mac_address,
   input  logic [arpc_pkg::TS_W-1:0]   req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [arpc_pkg::ST_W-1:0]   rsp_status,
   output logic [arpc_pkg::MAC_W-1:0]  rsp_mac_result
);

   // request registers
   logic                          action_ff;
   logic [arpc_pkg::IP_W-1:0]     ip_ff;
   logic [arpc_pkg::MAC_W-1:0]    mac_ff;
   logic [arpc_pkg::TS_W-1:0]     now_ff;

   // entry table
   logic [arpc_pkg::ENTRIES-1:0]  valid_ff;
   logic [arpc_pkg::IP_W-1:0]     tab_ip_ff   [arpc_pkg::ENTRIES];
   logic [arpc_pkg::MAC_W-1:0]    tab_mac_ff  [arpc_pkg::ENTRIES];
   logic [arpc_pkg::TS_W-1:0]     tab_ts_ff   [arpc_pkg::ENTRIES];

   // slot selection and lru scan
   logic [arpc_pkg::IDX_W-1:0]    slot_ff, slot_in;
   logic [arpc_pkg::IDX_W-1:0]    scan_ff, scan_in;
   logic [arpc_pkg::TS_W-1:0]     cand_ts_ff, cand_ts_in;

   // response register
   logic                          rsp_valid_ff;
   logic [arpc_pkg::ST_W-1:0]     rsp_status_ff;
   logic [arpc_pkg::MAC_W-1:0]    rsp_mac_ff;

   logic                          hit;
   logic [arpc_pkg::IDX_W-1:0]    hit_idx;
   logic                          has_free;
   logic [arpc_pkg::IDX_W-1:0]    free_idx;
   logic [arpc_pkg::TS_W-1:0]     scan_diff;
   logic                          scan_older;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         ip_ff     <= req_ip_address;
         mac_ff    <= req_mac_address;
         now_ff    <= req_now_ms;
      end
   end

   // lowest matching and lowest free entry
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      has_free = 1'b0;
      free_idx = '0;
      for (int i = arpc_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tab_ip_ff[i] == ip_ff)) begin
            hit     = 1'b1;
            hit_idx = arpc_pkg::IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = arpc_pkg::IDX_W'(i);
         end
      end
   end

   // wrap-aware age compare against the current candidate
   assign scan_diff  = tab_ts_ff[scan_ff] - cand_ts_ff;
   assign scan_older = scan_diff[arpc_pkg::TS_W-1];

   always_comb begin
      slot_in    = slot_ff;
      scan_in    = scan_ff;
      cand_ts_in = cand_ts_ff;
      case (cmd.slot_sel)
         arpc_pkg::SEL_HOLD: begin
         end
         arpc_pkg::SEL_HIT: begin
            slot_in = hit_idx;
         end
         arpc_pkg::SEL_FREE: begin
            slot_in = free_idx;
         end
         arpc_pkg::SEL_FIRST: begin
            slot_in    = '0;
            cand_ts_in = tab_ts_ff[0];
            scan_in    = arpc_pkg::IDX_W'(1);
         end
         arpc_pkg::SEL_SCAN: begin
            if (scan_older) begin
               slot_in    = scan_ff;
               cand_ts_in = tab_ts_ff[scan_ff];
            end
            scan_in = scan_ff + arpc_pkg::IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      scan_ff    <= scan_in;
      cand_ts_ff <= cand_ts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && (cmd.op == arpc_pkg::OP_FILL)) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (cmd.op == arpc_pkg::OP_FILL)) begin
         tab_ip_ff[slot_ff]  <= ip_ff;
         tab_mac_ff[slot_ff] <= mac_ff;
         tab_ts_ff[slot_ff]  <= now_ff;
      end else if (cmd.commit && (cmd.op == arpc_pkg::OP_TOUCH)) begin
         tab_ts_ff[slot_ff]  <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= cmd.status;
         rsp_mac_ff    <= (cmd.op == arpc_pkg::OP_TOUCH) ? tab_mac_ff[slot_ff] : '0;
      end
   end

   assign stat.is_lookup = (action_ff == arpc_pkg::ACT_LOOKUP);
   assign stat.ip_zero   = (ip_ff == '0);
   assign stat.hit       = hit;
   assign stat.has_free  = has_free;
   assign stat.last_scan = (scan_ff == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1));
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_mac_result = rsp_mac_ff;

endmodule

### rtl/arp_cache_lru.sv
// ----------------------------------------------------------------------------
// arp_cache_lru
// Fully associative IPv4 to MAC cache with least recently used replacement.
//
//   channel  ports                                   direction
//   req      req_valid/req_stall, action, ip, mac, now  in
//   rsp      rsp_valid/rsp_stall, status, mac_result   out
//
// a request is taken only while the sequencer is idle; one response each.
// hit, free entry, miss or error: the request goes through match and write;
// the response is registered at commit, and the sequencer returns to idle.
// a full-table update miss adds the lru scan, one lru compare a cycle.
// the response register lets the next request in while a response is stalled.
// synchronous reset clears the valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module arp_cache_lru (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [arpc_pkg::IP_W-1:0]   req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]  req_mac_address,
   input  logic [arpc_pkg::TS_W-1:0]   req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [arpc_pkg::ST_W-1:0]   rsp_status,
   output logic [arpc_pkg::MAC_W-1:0]  rsp_mac_result
);

   arpc_pkg::cmd_type   cmd;
   arpc_pkg::stat_type  stat;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   arpc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_ip_address  (req_ip_address),
      .req_mac_address (req_mac_address),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_mac_result  (rsp_mac_result)
   );

`ifndef NO_ASSERTIONS
   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   // a response is never committed over one still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !cmd.commit)
      else $error("response overwritten while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == arpc_pkg::ST_OK) || (rsp_status == arpc_pkg::ST_NOT_FOUND)
                    || (rsp_status == arpc_pkg::ST_INVALID))
      else $error("illegal response status");

   // only a lookup hit carries a mac
   a_mac_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (cmd.op != arpc_pkg::OP_TOUCH) |=> rsp_mac_result == '0)
      else $error("mac returned without lookup hit");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for arp_cache_lru. A predictor class keeps its own copy
// of the address table, works out the status and MAC of every accepted
// request, and compares each response against the oldest expectation. A
// directed opening covers the corner cases: zero addresses, hits and misses,
// wrap-aware eviction and ties. Random phases follow with different amounts
// of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 12;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 100;

   class arp_cache_predictor_type;
      bit                         slot_used  [arpc_pkg::ENTRIES];
      logic [arpc_pkg::IP_W-1:0]  slot_ip    [arpc_pkg::ENTRIES];
      logic [arpc_pkg::MAC_W-1:0] slot_mac   [arpc_pkg::ENTRIES];
      logic [arpc_pkg::TS_W-1:0]  slot_stamp [arpc_pkg::ENTRIES];
      logic [arpc_pkg::ST_W-1:0]  want_status [$];
      logic [arpc_pkg::MAC_W-1:0] want_mac [$];
      int                         mismatch_count = 0;

      function int find_entry(logic [arpc_pkg::IP_W-1:0] ip);
         for (int i = 0; i < arpc_pkg::ENTRIES; i++)
            if (slot_used[i] && slot_ip[i] == ip) return i;
         return arpc_pkg::ENTRIES;
      endfunction

      function int pending();
         return want_status.size();
      endfunction

      function void note_request(logic action, logic [arpc_pkg::IP_W-1:0] ip,
                                 logic [arpc_pkg::MAC_W-1:0] mac,
                                 logic [arpc_pkg::TS_W-1:0] now);
         int                        slot;
         logic [arpc_pkg::TS_W-1:0] gap;
         slot = find_entry(ip);
         if (action == arpc_pkg::ACT_UPDATE) begin
            if (ip == '0) begin
               want_status.push_back(arpc_pkg::ST_INVALID);
               want_mac.push_back('0);
               return;
            end
            if (slot == arpc_pkg::ENTRIES) begin
               slot = -1;
               for (int i = 0; i < arpc_pkg::ENTRIES; i++)
                  if (!slot_used[i] && slot < 0) slot = i;
               // full table: oldest stamp by signed difference, ties keep the lower index
               if (slot < 0) begin
                  slot = 0;
                  for (int i = 1; i < arpc_pkg::ENTRIES; i++) begin
                     gap = slot_stamp[i] - slot_stamp[slot];
                     if (gap[arpc_pkg::TS_W-1]) slot = i;
                  end
               end
            end
            slot_used[slot]  = 1'b1;
            slot_ip[slot]    = ip;
            slot_mac[slot]   = mac;
            slot_stamp[slot] = now;
            want_status.push_back(arpc_pkg::ST_OK);
            want_mac.push_back('0);
         end else if (slot < arpc_pkg::ENTRIES) begin
            want_status.push_back(arpc_pkg::ST_OK);
            want_mac.push_back(slot_mac[slot]);
            slot_stamp[slot] = now;
         end else begin
            want_status.push_back(arpc_pkg::ST_NOT_FOUND);
            want_mac.push_back('0);
         end
      endfunction

      function void check_response(logic [arpc_pkg::ST_W-1:0] status,
                                   logic [arpc_pkg::MAC_W-1:0] mac);
         logic [arpc_pkg::ST_W-1:0]  exp_status;
         logic [arpc_pkg::MAC_W-1:0] exp_mac;
         if (want_status.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
            return;
         end
         exp_status = want_status.pop_front();
         exp_mac    = want_mac.pop_front();
         if (status !== exp_status) begin
            $error("status: expected %0d, actual %0d", exp_status, status);
            mismatch_count++;
         end
         if (mac !== exp_mac) begin
            $error("mac_result: expected %h, actual %h", exp_mac, mac);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset           = 1'b1;
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic                        req_action      = arpc_pkg::ACT_UPDATE;
   logic [arpc_pkg::IP_W-1:0]   req_ip_address  = '0;
   logic [arpc_pkg::MAC_W-1:0]  req_mac_address = '0;
   logic [arpc_pkg::TS_W-1:0]   req_now_ms      = '0;
   logic                        rsp_valid;
   logic                        rsp_stall       = 1'b0;
   logic [arpc_pkg::ST_W-1:0]   rsp_status;
   logic [arpc_pkg::MAC_W-1:0]  rsp_mac_result;

   arp_cache_predictor_type predictor = new();

   int                          send_idle_pct = 0;
   int                          stall_pct     = 0;
   // hold-off requests from the sender and those taken by the receiver
   int                          hold_asked    = 0;
   int                          hold_taken    = 0;
   int                          hold_left     = 0;
   int                          cycle_count   = 0;
   logic [arpc_pkg::TS_W-1:0]   tick_ms;
   logic [arpc_pkg::IP_W-1:0]   key_pool [POOL_SIZE];

   arp_cache_lru uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_ip_address  (req_ip_address),
      .req_mac_address (req_mac_address),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_mac_result  (rsp_mac_result)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         predictor.check_response(rsp_status, rsp_mac_result);
   end

   task automatic send_request(logic action, logic [arpc_pkg::IP_W-1:0] ip,
                               logic [arpc_pkg::MAC_W-1:0] mac,
                               logic [arpc_pkg::TS_W-1:0] now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_ip_address  <= ip;
      req_mac_address <= mac;
      req_now_ms      <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predictor.note_request(action, ip, mac, now);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      // quiet cycles between phases
      repeat (arpc_pkg::ENTRIES + 4) @(posedge clock);
   endtask

   task automatic run_phase(int idle, int stall, bit with_hold);
      int                          pick;
      logic                        action;
      logic [arpc_pkg::IP_W-1:0]   ip;
      logic [63:0]                 mac_word;
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int i = 0; i < POOL_SIZE; i++) begin
         do key_pool[i] = $urandom; while (key_pool[i] == '0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick     = $urandom_range(0, 99);
         action   = ($urandom_range(0, 99) < 45) ? arpc_pkg::ACT_LOOKUP : arpc_pkg::ACT_UPDATE;
         mac_word = {$urandom, $urandom};
         if (pick < 85)
            ip = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick < 95)
            ip = $urandom;
         else
            ip = '0;
         if ($urandom_range(0, 19) == 0)
            tick_ms = $urandom;
         else
            tick_ms = tick_ms + $urandom_range(0, 5);
         if (with_hold && n == 20)
            hold_asked <= hold_asked + 1;
         send_request(action, ip, mac_word[arpc_pkg::MAC_W-1:0], tick_ms);
      end
   endtask

   initial begin
      logic [arpc_pkg::IP_W-1:0]  ip;
      logic [arpc_pkg::MAC_W-1:0] mac;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: zero keys and a plain miss
      tick_ms = 32'hFFFF_FFF0;
      send_request(arpc_pkg::ACT_LOOKUP, '0, 48'h0000_0000_1234, tick_ms);
      send_request(arpc_pkg::ACT_UPDATE, '0, '1, tick_ms);
      send_request(arpc_pkg::ACT_LOOKUP, 32'h0A00_0001, '0, tick_ms);

      // fill every entry; stamps cross the wrap and the first two tie
      for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
         ip = (i == arpc_pkg::ENTRIES - 1) ? 32'hFFFF_FFFF : 32'h0A00_0001 + i;
         mac = (i == 0) ? '1 : (i == 1) ? '0 : {8'h02, 8'(i), ip};
         if (i != 1) tick_ms = tick_ms + 4;
         send_request(arpc_pkg::ACT_UPDATE, ip, mac, tick_ms);
      end

      tick_ms = tick_ms + 4;
      send_request(arpc_pkg::ACT_UPDATE, 32'h0B00_0001, 48'hA5A5_5A5A_0001, tick_ms);
      send_request(arpc_pkg::ACT_LOOKUP, 32'h0A00_0001, '0, tick_ms);
      tick_ms = tick_ms + 4;
      send_request(arpc_pkg::ACT_LOOKUP, 32'h0A00_0002, '0, tick_ms);
      tick_ms = tick_ms + 4;
      send_request(arpc_pkg::ACT_UPDATE, 32'h0A00_0003, 48'h0F0F_F0F0_0003, tick_ms);
      tick_ms = tick_ms + 4;
      send_request(arpc_pkg::ACT_UPDATE, 32'h8000_0000, 48'h8000_0000_0000, tick_ms);
      send_request(arpc_pkg::ACT_LOOKUP, '0, '0, tick_ms);
      send_request(arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, '1, tick_ms);
      send_request(arpc_pkg::ACT_LOOKUP, 32'h0A00_0003, '0, tick_ms);
      tick_ms = tick_ms + 32'h8000_0000;
      send_request(arpc_pkg::ACT_UPDATE, 32'h0B00_0002, 48'h7FFF_FFFF_FFFF, tick_ms);
      send_request(arpc_pkg::ACT_LOOKUP, 32'h0B00_0002, '0, tick_ms);
      wait_drained();

      run_phase(0, 0, 1'b1);
      wait_drained();
      run_phase(76, 0, 1'b0);
      wait_drained();
      run_phase(0, 76, 1'b0);
      wait_drained();
      run_phase(26, 26, 1'b0);
      wait_drained();

      if (predictor.mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
